### hw/rtl/pts_pkg.sv
// Shared types, codes and per-digit helper functions of the Pascal token scanner.
package pts_pkg;

    localparam int LINE_BITS_DEFAULT = 16;
    localparam int MANTISSA_DIGITS   = 18;

    // Token kinds.
    localparam logic [2:0] KIND_EOF    = 3'd0;
    localparam logic [2:0] KIND_WORD   = 3'd1;
    localparam logic [2:0] KIND_INT    = 3'd2;
    localparam logic [2:0] KIND_REAL   = 3'd3;
    localparam logic [2:0] KIND_SCHAR  = 3'd4;
    localparam logic [2:0] KIND_SEND   = 3'd5;
    localparam logic [2:0] KIND_SPEC   = 3'd6;
    localparam logic [2:0] KIND_ERROR  = 3'd7;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_NUM   = 3'd1;
    localparam logic [2:0] ERR_INT_RANGE = 3'd2;
    localparam logic [2:0] ERR_REAL_RNG  = 3'd3;
    localparam logic [2:0] ERR_EOF_STR   = 3'd4;
    localparam logic [2:0] ERR_BAD_CHAR  = 3'd5;

    // Special symbol codes.
    localparam logic [4:0] SYM_NONE      = 5'd0;
    localparam logic [4:0] SYM_PLUS      = 5'd1;
    localparam logic [4:0] SYM_MINUS     = 5'd2;
    localparam logic [4:0] SYM_STAR      = 5'd3;
    localparam logic [4:0] SYM_SLASH     = 5'd4;
    localparam logic [4:0] SYM_ASSIGN    = 5'd5;
    localparam logic [4:0] SYM_PERIOD    = 5'd6;
    localparam logic [4:0] SYM_COMMA     = 5'd7;
    localparam logic [4:0] SYM_SEMI      = 5'd8;
    localparam logic [4:0] SYM_COLON     = 5'd9;
    localparam logic [4:0] SYM_EQ        = 5'd10;
    localparam logic [4:0] SYM_NE        = 5'd11;
    localparam logic [4:0] SYM_LT        = 5'd12;
    localparam logic [4:0] SYM_LE        = 5'd13;
    localparam logic [4:0] SYM_GE        = 5'd14;
    localparam logic [4:0] SYM_GT        = 5'd15;
    localparam logic [4:0] SYM_LPAREN    = 5'd16;
    localparam logic [4:0] SYM_RPAREN    = 5'd17;
    localparam logic [4:0] SYM_LBRACK    = 5'd18;
    localparam logic [4:0] SYM_RBRACK    = 5'd19;
    localparam logic [4:0] SYM_RBRACE    = 5'd20;
    localparam logic [4:0] SYM_CARET     = 5'd21;
    localparam logic [4:0] SYM_DOTDOT    = 5'd22;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam logic [10:0] EXP_LIMIT_RESET = 11'd1024;

    // APB register byte offsets.
    localparam logic [2:0] REG_EXP_LIMIT = 3'd0;

    typedef enum logic [14:0] {
        M_IDLE       = 15'b000000000000001,
        M_COMMENT    = 15'b000000000000010,
        M_WORD       = 15'b000000000000100,
        M_WHOLE      = 15'b000000000001000,
        M_DOT        = 15'b000000000010000,
        M_FRAC       = 15'b000000000100000,
        M_EXP_START  = 15'b000000001000000,
        M_EXP_SIGN   = 15'b000000010000000,
        M_EXP_DIGITS = 15'b000000100000000,
        M_STRING     = 15'b000001000000000,
        M_STR_QUOTE  = 15'b000010000000000,
        M_COLON      = 15'b000100000000000,
        M_LESS       = 15'b001000000000000,
        M_GREATER    = 15'b010000000000000,
        M_PERIOD     = 15'b100000000000000
    } mode_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  sym;
        logic [2:0]  err;
        logic [30:0] int_val;
        logic [59:0] mant;
        logic [11:0] expo;
        logic [7:0]  schar;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] len;
        logic        last;
    } res_t;

    // Number accumulation state.
    typedef struct packed {
        logic [30:0] int_acc;
        logic        ovf;
        logic [59:0] mant;
        logic [4:0]  sig;
        logic [15:0] whole;
        logic [15:0] frac;
        logic [15:0] kept;
        logic [30:0] exp_acc;
        logic        neg;
    } num_t;

    function automatic logic [15:0] sat16_inc(input logic [15:0] v);
        return (v != 16'hFFFF) ? v + 16'd1 : v;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic [4:0] single_symbol(input logic [7:0] c);
        logic [4:0] s;
        case (c)
            "+":     s = SYM_PLUS;
            "-":     s = SYM_MINUS;
            "*":     s = SYM_STAR;
            "/":     s = SYM_SLASH;
            ",":     s = SYM_COMMA;
            ";":     s = SYM_SEMI;
            "=":     s = SYM_EQ;
            "(":     s = SYM_LPAREN;
            ")":     s = SYM_RPAREN;
            "[":     s = SYM_LBRACK;
            "]":     s = SYM_RBRACK;
            "}":     s = SYM_RBRACE;
            "^":     s = SYM_CARET;
            default: s = SYM_NONE;
        endcase
        return s;
    endfunction

    function automatic res_t base_res(input logic [2:0] kind, input logic [15:0] line,
                                      input logic [15:0] col, input logic [15:0] len);
        res_t r;
        r = '0;
        r.kind = kind;
        r.line = line;
        r.col  = col;
        r.len  = len;
        return r;
    endfunction

    // Append one digit to the significand, dropping digits once MANTISSA_DIGITS significant digits are held.
    function automatic num_t absorb(input num_t n, input logic [3:0] d);
        num_t o;
        o = n;
        if (n.sig < 5'(MANTISSA_DIGITS))
        begin
            o.mant = {n.mant[56:0], 3'b000} + {n.mant[58:0], 1'b0} + 60'(d);
            if (o.mant != 60'd0)
            begin
                o.sig = n.sig + 5'd1;
            end
            o.kept = sat16_inc(n.kept);
        end
        return o;
    endfunction

    function automatic num_t whole_digit(input num_t n, input logic [3:0] d);
        num_t        o;
        logic [34:0] v;
        o = n;
        v = {1'b0, n.int_acc, 3'b000} + {3'b000, n.int_acc, 1'b0} + 35'(d);
        if (!n.ovf)
        begin
            if (v > 35'h7FFFFFFF)
            begin
                o.ovf = 1'b1;
            end
            else
            begin
                o.int_acc = v[30:0];
            end
        end
        o = absorb(o, d);
        o.whole = sat16_inc(n.whole);
        return o;
    endfunction

    function automatic num_t exp_digit(input num_t n, input logic [3:0] d);
        num_t        o;
        logic [34:0] v;
        o = n;
        v = {1'b0, n.exp_acc, 3'b000} + {3'b000, n.exp_acc, 1'b0} + 35'(d);
        if (!n.ovf)
        begin
            if (v > 35'h7FFFFFFF)
            begin
                o.ovf = 1'b1;
            end
            else
            begin
                o.exp_acc = v[30:0];
            end
        end
        return o;
    endfunction

    function automatic res_t int_res(input res_t b, input num_t n);
        res_t r;
        r = b;
        if (n.ovf)
        begin
            r.kind = KIND_ERROR;
            r.err  = ERR_INT_RANGE;
        end
        else
        begin
            r.kind    = KIND_INT;
            r.int_val = n.int_acc;
        end
        return r;
    endfunction

    function automatic res_t real_res(input res_t b, input num_t n, input logic [10:0] limit);
        res_t               r;
        logic signed [33:0] ev;
        logic signed [33:0] chk;
        logic signed [33:0] rep;
        r   = b;
        ev  = n.neg ? -$signed({3'b000, n.exp_acc}) : $signed({3'b000, n.exp_acc});
        chk = ev - $signed({18'd0, n.frac}) + $signed({18'd0, n.whole});
        if (chk < 0)
        begin
            chk = -chk;
        end
        rep = ev + $signed({18'd0, n.whole}) - $signed({18'd0, n.kept});
        if (n.mant == 60'd0)
        begin
            rep = '0;
        end
        if (n.ovf)
        begin
            r.kind = KIND_ERROR;
            r.err  = ERR_BAD_NUM;
        end
        else if (chk > $signed({23'd0, limit}) || rep < -34'sd2048 || rep > 34'sd2047)
        begin
            r.kind = KIND_ERROR;
            r.err  = ERR_REAL_RNG;
        end
        else
        begin
            r.kind = KIND_REAL;
            r.mant = n.mant;
            r.expo = rep[11:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/pts_cfg_regs.sv
// APB-style configuration register file holding the real exponent limit.
module pts_cfg_regs
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [10:0] exp_limit
);

    logic [10:0] limit_reg;
    logic [10:0] limit_next;

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && paddr[2] == pts_pkg::REG_EXP_LIMIT[2])
        begin
            limit_next = pwdata[10:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= pts_pkg::EXP_LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    // Low byte-offset bits are ignored, only one register exists.
    assign prdata    = (paddr[2] == pts_pkg::REG_EXP_LIMIT[2]) ? {21'd0, limit_reg} : 32'd0;
    assign pready    = 1'b1;
    assign exp_limit = limit_reg;

endmodule

### hw/rtl/pts_scanner.sv
// Scanner state and the per-character next-state and token logic.
module pts_scanner #(
    parameter int LINE_BITS = pts_pkg::LINE_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         char_code,
    input  logic               end_of_input,
    input  logic [10:0]        exp_limit,
    output pts_pkg::res_t      res0,
    output pts_pkg::res_t      res1,
    output logic [1:0]         res_count
);

    pts_pkg::mode_t         mode_reg, mode_next;
    pts_pkg::num_t          num_reg, num_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [LINE_BITS-1:0]   col_reg, col_next;
    logic [LINE_BITS-1:0]   tline_reg, tline_next;
    logic [LINE_BITS-1:0]   tcol_reg, tcol_next;
    logic [15:0]            len_reg, len_next;

    pts_pkg::res_t          res_v [2];
    logic [1:0]             n_v;
    logic                   redo;
    logic                   dg;
    logic [3:0]             dval;
    logic [4:0]             s;

    function automatic logic [LINE_BITS-1:0] pos_inc(input logic [LINE_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        num_next   = num_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        len_next   = len_reg;
        res_v[0]   = '0;
        res_v[1]   = '0;
        n_v        = 2'd0;
        redo       = 1'b0;
        s          = pts_pkg::SYM_NONE;
        dg         = pts_pkg::is_digit(char_code);
        dval       = char_code[3:0];

        if (end_of_input)
        begin
            // Close whatever token is open, then report end of file.
            case (mode_reg)
                pts_pkg::M_WORD:
                begin
                    res_v[0] = pts_pkg::base_res(pts_pkg::KIND_WORD, 16'(tline_reg),
                                                 16'(tcol_reg), len_reg);
                    n_v = 2'd1;
                end
                pts_pkg::M_WHOLE:
                begin
                    res_v[0] = pts_pkg::int_res(pts_pkg::base_res(pts_pkg::KIND_INT,
                               16'(tline_reg), 16'(tcol_reg), len_reg), num_reg);
                    n_v = 2'd1;
                end
                pts_pkg::M_DOT:
                begin
                    len_next = pts_pkg::sat16_inc(len_reg);
                    res_v[0] = pts_pkg::base_res(pts_pkg::KIND_ERROR, 16'(tline_reg),
                                                 16'(tcol_reg), len_next);
                    res_v[0].err = pts_pkg::ERR_BAD_NUM;
                    n_v = 2'd1;
                end
                pts_pkg::M_FRAC, pts_pkg::M_EXP_DIGITS:
                begin
                    res_v[0] = pts_pkg::real_res(pts_pkg::base_res(pts_pkg::KIND_REAL,
                               16'(tline_reg), 16'(tcol_reg), len_reg), num_reg, exp_limit);
                    n_v = 2'd1;
                end
                pts_pkg::M_EXP_START, pts_pkg::M_EXP_SIGN, pts_pkg::M_STRING:
                begin
                    res_v[0] = pts_pkg::base_res(pts_pkg::KIND_ERROR, 16'(tline_reg),
                                                 16'(tcol_reg), len_reg);
                    res_v[0].err = (mode_reg == pts_pkg::M_STRING) ? pts_pkg::ERR_EOF_STR
                                                                   : pts_pkg::ERR_BAD_NUM;
                    n_v = 2'd1;
                end
                pts_pkg::M_STR_QUOTE:
                begin
                    res_v[0] = pts_pkg::base_res(pts_pkg::KIND_SEND, 16'(tline_reg),
                                                 16'(tcol_reg), len_reg);
                    n_v = 2'd1;
                end
                pts_pkg::M_COLON, pts_pkg::M_LESS, pts_pkg::M_GREATER, pts_pkg::M_PERIOD:
                begin
                    res_v[0] = pts_pkg::base_res(pts_pkg::KIND_SPEC, 16'(tline_reg),
                                                 16'(tcol_reg), len_reg);
                    case (mode_reg)
                        pts_pkg::M_COLON:   res_v[0].sym = pts_pkg::SYM_COLON;
                        pts_pkg::M_LESS:    res_v[0].sym = pts_pkg::SYM_LT;
                        pts_pkg::M_GREATER: res_v[0].sym = pts_pkg::SYM_GT;
                        default:            res_v[0].sym = pts_pkg::SYM_PERIOD;
                    endcase
                    n_v = 2'd1;
                end
                default:
                begin
                    n_v = 2'd0;
                end
            endcase
            mode_next = pts_pkg::M_IDLE;
            res_v[n_v[0]] = pts_pkg::base_res(pts_pkg::KIND_EOF, 16'(line_reg),
                                              16'(col_reg), 16'd0);
            n_v = n_v + 2'd1;
        end
        else
        begin
            case (mode_reg)
                pts_pkg::M_COMMENT:
                begin
                    if (char_code == "}")
                    begin
                        mode_next = pts_pkg::M_IDLE;
                    end
                end
                pts_pkg::M_WORD:
                begin
                    if (pts_pkg::is_alpha(char_code) || dg || char_code == "_")
                    begin
                        len_next = pts_pkg::sat16_inc(len_reg);
                    end
                    else
                    begin
                        res_v[0] = pts_pkg::base_res(pts_pkg::KIND_WORD, 16'(tline_reg),
                                                     16'(tcol_reg), len_reg);
                        n_v  = 2'd1;
                        redo = 1'b1;
                    end
                end
                pts_pkg::M_WHOLE:
                begin
                    if (dg)
                    begin
                        num_next = pts_pkg::whole_digit(num_reg, dval);
                        len_next = pts_pkg::sat16_inc(len_reg);
                    end
                    else if (char_code == ".")
                    begin
                        mode_next = pts_pkg::M_DOT;
                    end
                    else if (char_code == "E" || char_code == "e")
                    begin
                        len_next     = pts_pkg::sat16_inc(len_reg);
                        num_next.ovf = 1'b0;
                        mode_next    = pts_pkg::M_EXP_START;
                    end
                    else
                    begin
                        res_v[0] = pts_pkg::int_res(pts_pkg::base_res(pts_pkg::KIND_INT,
                                   16'(tline_reg), 16'(tcol_reg), len_reg), num_reg);
                        n_v  = 2'd1;
                        redo = 1'b1;
                    end
                end
                pts_pkg::M_DOT:
                begin
                    if (char_code == ".")
                    begin
                        // The held dot and this one form a range symbol.
                        res_v[0] = pts_pkg::int_res(pts_pkg::base_res(pts_pkg::KIND_INT,
                                   16'(tline_reg), 16'(tcol_reg), len_reg), num_reg);
                        tline_next = line_reg;
                        tcol_next  = (col_reg != '0) ? col_reg - 1'b1 : col_reg;
                        len_next   = 16'd2;
                        res_v[1]   = pts_pkg::base_res(pts_pkg::KIND_SPEC, 16'(line_reg),
                                                       16'(tcol_next), 16'd2);
                        res_v[1].sym = pts_pkg::SYM_DOTDOT;
                        n_v       = 2'd2;
                        mode_next = pts_pkg::M_IDLE;
                    end
                    else if (dg)
                    begin
                        len_next     = pts_pkg::sat16_inc(pts_pkg::sat16_inc(len_reg));
                        num_next     = num_reg;
                        num_next.ovf = 1'b0;
                        num_next     = pts_pkg::absorb(num_next, dval);
                        num_next.frac = pts_pkg::sat16_inc(num_reg.frac);
                        mode_next    = pts_pkg::M_FRAC;
                    end
                    else
                    begin
                        len_next = pts_pkg::sat16_inc(len_reg);
                        res_v[0] = pts_pkg::base_res(pts_pkg::KIND_ERROR, 16'(tline_reg),
                                                     16'(tcol_reg), len_next);
                        res_v[0].err = pts_pkg::ERR_BAD_NUM;
                        n_v  = 2'd1;
                        redo = 1'b1;
                    end
                end
                pts_pkg::M_FRAC:
                begin
                    if (dg)
                    begin
                        num_next      = pts_pkg::absorb(num_reg, dval);
                        num_next.frac = pts_pkg::sat16_inc(num_reg.frac);
                        len_next      = pts_pkg::sat16_inc(len_reg);
                    end
                    else if (char_code == "E" || char_code == "e")
                    begin
                        len_next     = pts_pkg::sat16_inc(len_reg);
                        num_next.ovf = 1'b0;
                        mode_next    = pts_pkg::M_EXP_START;
                    end
                    else
                    begin
                        res_v[0] = pts_pkg::real_res(pts_pkg::base_res(pts_pkg::KIND_REAL,
                                   16'(tline_reg), 16'(tcol_reg), len_reg), num_reg, exp_limit);
                        n_v  = 2'd1;
                        redo = 1'b1;
                    end
                end
                pts_pkg::M_EXP_START, pts_pkg::M_EXP_SIGN:
                begin
                    if (mode_reg == pts_pkg::M_EXP_START && (char_code == "+" || char_code == "-"))
                    begin
                        len_next     = pts_pkg::sat16_inc(len_reg);
                        num_next.neg = (char_code == "-");
                        mode_next    = pts_pkg::M_EXP_SIGN;
                    end
                    else if (dg)
                    begin
                        len_next  = pts_pkg::sat16_inc(len_reg);
                        num_next  = pts_pkg::exp_digit(num_reg, dval);
                        mode_next = pts_pkg::M_EXP_DIGITS;
                    end
                    else
                    begin
                        res_v[0] = pts_pkg::base_res(pts_pkg::KIND_ERROR, 16'(tline_reg),
                                                     16'(tcol_reg), len_reg);
                        res_v[0].err = pts_pkg::ERR_BAD_NUM;
                        n_v  = 2'd1;
                        redo = 1'b1;
                    end
                end
                pts_pkg::M_EXP_DIGITS:
                begin
                    if (dg)
                    begin
                        len_next = pts_pkg::sat16_inc(len_reg);
                        num_next = pts_pkg::exp_digit(num_reg, dval);
                    end
                    else
                    begin
                        res_v[0] = pts_pkg::real_res(pts_pkg::base_res(pts_pkg::KIND_REAL,
                                   16'(tline_reg), 16'(tcol_reg), len_reg), num_reg, exp_limit);
                        n_v  = 2'd1;
                        redo = 1'b1;
                    end
                end
                pts_pkg::M_STRING:
                begin
                    len_next = pts_pkg::sat16_inc(len_reg);
                    if (char_code == pts_pkg::CH_QUOTE)
                    begin
                        mode_next = pts_pkg::M_STR_QUOTE;
                    end
                    else
                    begin
                        res_v[0] = pts_pkg::base_res(pts_pkg::KIND_SCHAR, 16'(tline_reg),
                                                     16'(tcol_reg), len_next);
                        res_v[0].schar = pts_pkg::is_space(char_code) ? pts_pkg::CH_SPACE
                                                                      : char_code;
                        n_v = 2'd1;
                    end
                end
                pts_pkg::M_STR_QUOTE:
                begin
                    if (char_code == pts_pkg::CH_QUOTE)
                    begin
                        // A doubled quote stands for one quote character.
                        len_next = pts_pkg::sat16_inc(len_reg);
                        res_v[0] = pts_pkg::base_res(pts_pkg::KIND_SCHAR, 16'(tline_reg),
                                                     16'(tcol_reg), len_next);
                        res_v[0].schar = pts_pkg::CH_QUOTE;
                        n_v       = 2'd1;
                        mode_next = pts_pkg::M_STRING;
                    end
                    else
                    begin
                        res_v[0] = pts_pkg::base_res(pts_pkg::KIND_SEND, 16'(tline_reg),
                                                     16'(tcol_reg), len_reg);
                        n_v  = 2'd1;
                        redo = 1'b1;
                    end
                end
                pts_pkg::M_COLON, pts_pkg::M_LESS, pts_pkg::M_GREATER, pts_pkg::M_PERIOD:
                begin
                    case (mode_reg)
                        pts_pkg::M_COLON:
                            s = (char_code == "=") ? pts_pkg::SYM_ASSIGN : pts_pkg::SYM_NONE;
                        pts_pkg::M_LESS:
                            s = (char_code == "=") ? pts_pkg::SYM_LE :
                                (char_code == ">") ? pts_pkg::SYM_NE : pts_pkg::SYM_NONE;
                        pts_pkg::M_GREATER:
                            s = (char_code == "=") ? pts_pkg::SYM_GE : pts_pkg::SYM_NONE;
                        default:
                            s = (char_code == ".") ? pts_pkg::SYM_DOTDOT : pts_pkg::SYM_NONE;
                    endcase
                    if (s != pts_pkg::SYM_NONE)
                    begin
                        len_next  = pts_pkg::sat16_inc(len_reg);
                        mode_next = pts_pkg::M_IDLE;
                        res_v[0]  = pts_pkg::base_res(pts_pkg::KIND_SPEC, 16'(tline_reg),
                                                      16'(tcol_reg), len_next);
                        res_v[0].sym = s;
                    end
                    else
                    begin
                        res_v[0] = pts_pkg::base_res(pts_pkg::KIND_SPEC, 16'(tline_reg),
                                                     16'(tcol_reg), len_reg);
                        case (mode_reg)
                            pts_pkg::M_COLON:   res_v[0].sym = pts_pkg::SYM_COLON;
                            pts_pkg::M_LESS:    res_v[0].sym = pts_pkg::SYM_LT;
                            pts_pkg::M_GREATER: res_v[0].sym = pts_pkg::SYM_GT;
                            default:            res_v[0].sym = pts_pkg::SYM_PERIOD;
                        endcase
                        redo = 1'b1;
                    end
                    n_v = 2'd1;
                end
                default:
                begin
                    redo = 1'b1;
                end
            endcase

            // Start of a new token from the idle state.
            if (redo)
            begin
                mode_next = pts_pkg::M_IDLE;
                if (pts_pkg::is_space(char_code))
                begin
                    mode_next = pts_pkg::M_IDLE;
                end
                else if (char_code == "{")
                begin
                    mode_next = pts_pkg::M_COMMENT;
                end
                else
                begin
                    tline_next = line_reg;
                    tcol_next  = col_reg;
                    len_next   = 16'd1;
                    if (pts_pkg::is_alpha(char_code))
                    begin
                        mode_next = pts_pkg::M_WORD;
                    end
                    else if (dg)
                    begin
                        num_next  = pts_pkg::whole_digit('0, dval);
                        mode_next = pts_pkg::M_WHOLE;
                    end
                    else if (char_code == pts_pkg::CH_QUOTE)
                    begin
                        mode_next = pts_pkg::M_STRING;
                    end
                    else if (char_code == ":")
                    begin
                        mode_next = pts_pkg::M_COLON;
                    end
                    else if (char_code == "<")
                    begin
                        mode_next = pts_pkg::M_LESS;
                    end
                    else if (char_code == ">")
                    begin
                        mode_next = pts_pkg::M_GREATER;
                    end
                    else if (char_code == ".")
                    begin
                        mode_next = pts_pkg::M_PERIOD;
                    end
                    else
                    begin
                        s = pts_pkg::single_symbol(char_code);
                        res_v[n_v[0]] = pts_pkg::base_res(pts_pkg::KIND_SPEC,
                                        16'(line_reg), 16'(col_reg), 16'd1);
                        if (s != pts_pkg::SYM_NONE)
                        begin
                            res_v[n_v[0]].sym = s;
                        end
                        else
                        begin
                            res_v[n_v[0]].kind = pts_pkg::KIND_ERROR;
                            res_v[n_v[0]].err  = pts_pkg::ERR_BAD_CHAR;
                        end
                        n_v = n_v + 2'd1;
                    end
                end
            end

            if (char_code == pts_pkg::CH_NL)
            begin
                line_next = pos_inc(line_reg);
                col_next  = '0;
            end
            else
            begin
                col_next = pos_inc(col_reg);
            end
        end

        if (n_v == 2'd1)
        begin
            res_v[0].last = 1'b1;
        end
        else if (n_v == 2'd2)
        begin
            res_v[1].last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= pts_pkg::M_IDLE;
            num_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= '0;
            tline_reg <= LINE_BITS'(1);
            tcol_reg  <= '0;
            len_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            num_reg   <= num_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            len_reg   <= len_next;
        end
    end

    assign res0      = res_v[0];
    assign res1      = res_v[1];
    assign res_count = n_v;

endmodule

### hw/rtl/pts_result_queue.sv
// Four-entry result queue that takes up to two results a cycle and gives one.
module pts_result_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_count,
    input  pts_pkg::res_t push0,
    input  pts_pkg::res_t push1,
    output logic          has_room,
    output logic          out_valid,
    input  logic          out_ready,
    output pts_pkg::res_t head
);

    pts_pkg::res_t store [4];
    logic [1:0]    rd_reg, rd_next;
    logic [1:0]    wr_reg, wr_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic          pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 3'd0);
    assign has_room  = (cnt_reg <= 3'd2);
    assign head      = store[rd_reg];

    always_comb
    begin
        rd_next  = rd_reg + 2'(pop);
        wr_next  = wr_reg + push_count;
        cnt_next = cnt_reg + 3'(push_count) - 3'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            store[wr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            store[wr_reg + 2'd1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### hw/rtl/pascal_token_scanner_core.sv
// Top level of the streaming Pascal token scanner.
// The scanner takes Pascal source one byte per beat (or an end-of-input beat)
// and returns tokens: words by position and length, range-checked integers,
// reals as a decimal significand with a power of ten, strings one character
// per result beat followed by a string-end beat, specials, and errors. Each
// input beat is captured in an input register and, once the result queue has
// room, handled by the scanner logic, which writes zero, one or two result
// beats into a four-entry result queue. An input beat is taken every cycle
// while the queue holds at most two results, so the sustained rate is one
// input beat per cycle as long as beats produce at most one result on average
// and the consumer takes one result per cycle; the queue's single output port
// bounds results to one per cycle. A beat passes through the input register,
// and its results are written into the result queue. The real exponent limit register sits at byte
// address 0 and should be written only while the scanner is idle.
module pascal_token_scanner_core #(
    parameter int LINE_BITS = pts_pkg::LINE_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  token_kind,
    output logic [4:0]  symbol_code,
    output logic [2:0]  error_code,
    output logic [30:0] int_value,
    output logic [59:0] real_mantissa,
    output logic signed [11:0] real_exponent,
    output logic [7:0]  string_char,
    output logic [15:0] start_line,
    output logic [15:0] start_column,
    output logic [15:0] token_length,
    output logic        last
);

    logic          vld_reg, vld_next;
    logic [7:0]    char_reg;
    logic          eoi_reg;
    logic          step;
    logic          room;
    logic [10:0]   exp_limit;
    pts_pkg::res_t res0, res1, head;
    logic [1:0]    res_count;

    // The held beat is handled once the queue can absorb two results.
    assign step     = vld_reg && room;
    assign in_ready = !vld_reg || step;
    assign vld_next = in_ready ? in_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
            eoi_reg  <= end_of_input;
        end
    end

    pts_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .exp_limit (exp_limit)
    );

    pts_scanner #(
        .LINE_BITS (LINE_BITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .char_code    (char_reg),
        .end_of_input (eoi_reg),
        .exp_limit    (exp_limit),
        .res0         (res0),
        .res1         (res1),
        .res_count    (res_count)
    );

    pts_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (step ? res_count : 2'd0),
        .push0      (res0),
        .push1      (res1),
        .has_room   (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .head       (head)
    );

    assign token_kind    = head.kind;
    assign symbol_code   = head.sym;
    assign error_code    = head.err;
    assign int_value     = head.int_val;
    assign real_mantissa = head.mant;
    assign real_exponent = head.expo;
    assign string_char   = head.schar;
    assign start_line    = head.line;
    assign start_column  = head.col;
    assign token_length  = head.len;
    assign last          = head.last;

endmodule

### dv/testbench.sv
// Self-checking testbench of the Pascal token scanner core.
module testbench;

    // Scanner modes of the predictor.
    typedef enum int {
        S_IDLE, S_COMMENT, S_WORD, S_WHOLE, S_DOT, S_FRAC, S_EXP_START, S_EXP_SIGN,
        S_EXP_DIGITS, S_STRING, S_STR_QUOTE, S_COLON, S_LESS, S_GREATER, S_PERIOD
    } scan_state_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } src_beat_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_code;
    logic        end_of_input;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  token_kind;
    logic [4:0]  symbol_code;
    logic [2:0]  error_code;
    logic [30:0] int_value;
    logic [59:0] real_mantissa;
    logic signed [11:0] real_exponent;
    logic [7:0]  string_char;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] token_length;
    logic        last;

    pascal_token_scanner_core DUT (.*);

    // Beats waiting for the driver, and tokens the scanner still owes us.
    src_beat_t       source_queue[$];
    pts_pkg::res_t   token_queue[$];
    int              mismatch_count;
    int              send_idle_pct;
    int              recv_stall_pct;
    bit              in_taken;

    // Predictor state, a private copy of the scanner's.
    scan_state_t p_mode;
    logic [10:0] p_limit;
    logic [31:0] p_int;
    bit          p_ovf;
    logic [63:0] p_mant;
    int          p_sig;
    int          p_whole;
    int          p_frac;
    int          p_kept;
    logic [31:0] p_exp;
    bit          p_neg;
    int          p_line;
    int          p_col;
    int          p_tline;
    int          p_tcol;
    int          p_len;
    int          step_count;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic bit ch_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit ch_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit ch_alpha(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic int sat_inc(int v);
        return v < 65535 ? v + 1 : v;
    endfunction

    function automatic logic [4:0] lone_symbol(logic [7:0] c);
        case (c)
            "+": return pts_pkg::SYM_PLUS;
            "-": return pts_pkg::SYM_MINUS;
            "*": return pts_pkg::SYM_STAR;
            "/": return pts_pkg::SYM_SLASH;
            ",": return pts_pkg::SYM_COMMA;
            ";": return pts_pkg::SYM_SEMI;
            "=": return pts_pkg::SYM_EQ;
            "(": return pts_pkg::SYM_LPAREN;
            ")": return pts_pkg::SYM_RPAREN;
            "[": return pts_pkg::SYM_LBRACK;
            "]": return pts_pkg::SYM_RBRACK;
            "}": return pts_pkg::SYM_RBRACE;
            "^": return pts_pkg::SYM_CARET;
            default: return pts_pkg::SYM_NONE;
        endcase
    endfunction

    // Queue one expected token, stamped with the current token position.
    task automatic push_token(logic [2:0] kind, logic [4:0] sym, logic [2:0] err,
                              logic [30:0] ival, logic [59:0] mant, logic [11:0] expo,
                              logic [7:0] sc);
        pts_pkg::res_t r;
        r = '0;
        r.kind = kind;
        r.sym = sym;
        r.err = err;
        r.int_val = ival;
        r.mant = mant;
        r.expo = expo;
        r.schar = sc;
        r.line = p_tline[15:0];
        r.col = p_tcol[15:0];
        r.len = p_len[15:0];
        token_queue.push_back(r);
        step_count++;
    endtask

    task automatic push_integer();
        if (p_ovf)
            push_token(pts_pkg::KIND_ERROR, pts_pkg::SYM_NONE, pts_pkg::ERR_INT_RANGE,
                       '0, '0, '0, '0);
        else
            push_token(pts_pkg::KIND_INT, pts_pkg::SYM_NONE, pts_pkg::ERR_NONE,
                       p_int[30:0], '0, '0, '0);
    endtask

    task automatic push_real();
        longint ev;
        longint chk;
        longint rep;
        ev = p_neg ? -longint'(p_exp) : longint'(p_exp);
        if (p_ovf)
        begin
            push_token(pts_pkg::KIND_ERROR, pts_pkg::SYM_NONE, pts_pkg::ERR_BAD_NUM,
                       '0, '0, '0, '0);
            return;
        end
        chk = ev - p_frac + p_whole;
        if (chk < 0)
            chk = -chk;
        rep = ev + p_whole - p_kept;
        if (p_mant == 0)
            rep = 0;
        if (chk > p_limit || rep < -2048 || rep > 2047)
            push_token(pts_pkg::KIND_ERROR, pts_pkg::SYM_NONE, pts_pkg::ERR_REAL_RNG,
                       '0, '0, '0, '0);
        else
            push_token(pts_pkg::KIND_REAL, pts_pkg::SYM_NONE, pts_pkg::ERR_NONE,
                       '0, p_mant[59:0], rep[11:0], '0);
    endtask

    task automatic take_digit(int d);
        if (p_sig < pts_pkg::MANTISSA_DIGITS)
        begin
            p_mant = p_mant * 10 + d;
            if (p_mant != 0)
                p_sig++;
            p_kept = sat_inc(p_kept);
        end
    endtask

    task automatic whole_step(int d);
        longint v;
        if (!p_ovf)
        begin
            v = longint'(p_int) * 10 + d;
            if (v > 64'h7FFFFFFF)
                p_ovf = 1;
            else
                p_int = v[31:0];
        end
        take_digit(d);
        p_whole = sat_inc(p_whole);
    endtask

    task automatic exp_step(int d);
        longint v;
        if (!p_ovf)
        begin
            v = longint'(p_exp) * 10 + d;
            if (v > 64'h7FFFFFFF)
                p_ovf = 1;
            else
                p_exp = v[31:0];
        end
    endtask

    task automatic start_from_idle(logic [7:0] c, int col);
        logic [4:0] s;
        p_mode = S_IDLE;
        if (ch_space(c))
            return;
        if (c == "{")
        begin
            p_mode = S_COMMENT;
            return;
        end
        p_tline = p_line;
        p_tcol = col;
        p_len = 1;
        if (ch_alpha(c))
            p_mode = S_WORD;
        else if (ch_digit(c))
        begin
            p_int = 0;
            p_ovf = 0;
            p_mant = 0;
            p_sig = 0;
            p_kept = 0;
            p_whole = 0;
            p_frac = 0;
            p_exp = 0;
            p_neg = 0;
            whole_step(c - 8'h30);
            p_mode = S_WHOLE;
        end
        else if (c == pts_pkg::CH_QUOTE)
            p_mode = S_STRING;
        else if (c == ":")
            p_mode = S_COLON;
        else if (c == "<")
            p_mode = S_LESS;
        else if (c == ">")
            p_mode = S_GREATER;
        else if (c == ".")
            p_mode = S_PERIOD;
        else
        begin
            s = lone_symbol(c);
            if (s != pts_pkg::SYM_NONE)
                push_token(pts_pkg::KIND_SPEC, s, pts_pkg::ERR_NONE, '0, '0, '0, '0);
            else
                push_token(pts_pkg::KIND_ERROR, pts_pkg::SYM_NONE, pts_pkg::ERR_BAD_CHAR,
                           '0, '0, '0, '0);
        end
    endtask

    // Advance the scanner by one character; redo is set when the character
    // closes the pending token and must be rescanned from idle.
    task automatic scan_char(input logic [7:0] c, input int col, output bit redo);
        bit dg;
        logic [4:0] two;
        logic [4:0] one;
        redo = 1'b0;
        dg = ch_digit(c);
        case (p_mode)
            S_COMMENT:
            begin
                if (c == "}")
                    p_mode = S_IDLE;
                return;
            end
            S_WORD:
            begin
                if (ch_alpha(c) || dg || c == "_")
                begin
                    p_len = sat_inc(p_len);
                    return;
                end
                push_token(pts_pkg::KIND_WORD, pts_pkg::SYM_NONE, pts_pkg::ERR_NONE,
                           '0, '0, '0, '0);
                redo = 1'b1;
            end
            S_WHOLE:
            begin
                if (dg)
                begin
                    whole_step(c - 8'h30);
                    p_len = sat_inc(p_len);
                    return;
                end
                if (c == ".")
                begin
                    p_mode = S_DOT;
                    return;
                end
                if (c == "E" || c == "e")
                begin
                    p_len = sat_inc(p_len);
                    p_ovf = 0;
                    p_mode = S_EXP_START;
                    return;
                end
                push_integer();
                redo = 1'b1;
            end
            S_DOT:
            begin
                if (c == ".")
                begin
                    push_integer();
                    p_tline = p_line;
                    p_tcol = col > 0 ? col - 1 : 0;
                    p_len = 2;
                    push_token(pts_pkg::KIND_SPEC, pts_pkg::SYM_DOTDOT, pts_pkg::ERR_NONE,
                               '0, '0, '0, '0);
                    p_mode = S_IDLE;
                    return;
                end
                p_len = sat_inc(p_len);
                if (dg)
                begin
                    p_len = sat_inc(p_len);
                    p_ovf = 0;
                    take_digit(c - 8'h30);
                    p_frac = sat_inc(p_frac);
                    p_mode = S_FRAC;
                    return;
                end
                push_token(pts_pkg::KIND_ERROR, pts_pkg::SYM_NONE, pts_pkg::ERR_BAD_NUM,
                           '0, '0, '0, '0);
                redo = 1'b1;
            end
            S_FRAC:
            begin
                if (dg)
                begin
                    take_digit(c - 8'h30);
                    p_frac = sat_inc(p_frac);
                    p_len = sat_inc(p_len);
                    return;
                end
                if (c == "E" || c == "e")
                begin
                    p_len = sat_inc(p_len);
                    p_ovf = 0;
                    p_mode = S_EXP_START;
                    return;
                end
                push_real();
                redo = 1'b1;
            end
            S_EXP_START, S_EXP_SIGN:
            begin
                if (p_mode == S_EXP_START && (c == "+" || c == "-"))
                begin
                    p_len = sat_inc(p_len);
                    p_neg = (c == "-");
                    p_mode = S_EXP_SIGN;
                    return;
                end
                if (dg)
                begin
                    p_len = sat_inc(p_len);
                    exp_step(c - 8'h30);
                    p_mode = S_EXP_DIGITS;
                    return;
                end
                push_token(pts_pkg::KIND_ERROR, pts_pkg::SYM_NONE, pts_pkg::ERR_BAD_NUM,
                           '0, '0, '0, '0);
                redo = 1'b1;
            end
            S_EXP_DIGITS:
            begin
                if (dg)
                begin
                    p_len = sat_inc(p_len);
                    exp_step(c - 8'h30);
                    return;
                end
                push_real();
                redo = 1'b1;
            end
            S_STRING:
            begin
                p_len = sat_inc(p_len);
                if (c == pts_pkg::CH_QUOTE)
                    p_mode = S_STR_QUOTE;
                else
                    push_token(pts_pkg::KIND_SCHAR, pts_pkg::SYM_NONE, pts_pkg::ERR_NONE,
                               '0, '0, '0, ch_space(c) ? pts_pkg::CH_SPACE : c);
            end
            S_STR_QUOTE:
            begin
                if (c == pts_pkg::CH_QUOTE)
                begin
                    p_len = sat_inc(p_len);
                    push_token(pts_pkg::KIND_SCHAR, pts_pkg::SYM_NONE, pts_pkg::ERR_NONE,
                               '0, '0, '0, pts_pkg::CH_QUOTE);
                    p_mode = S_STRING;
                    return;
                end
                push_token(pts_pkg::KIND_SEND, pts_pkg::SYM_NONE, pts_pkg::ERR_NONE,
                           '0, '0, '0, '0);
                redo = 1'b1;
            end
            S_COLON, S_LESS, S_GREATER, S_PERIOD:
            begin
                two = pts_pkg::SYM_NONE;
                one = pts_pkg::SYM_NONE;
                case (p_mode)
                    S_COLON:
                    begin
                        one = pts_pkg::SYM_COLON;
                        if (c == "=") two = pts_pkg::SYM_ASSIGN;
                    end
                    S_LESS:
                    begin
                        one = pts_pkg::SYM_LT;
                        if (c == "=") two = pts_pkg::SYM_LE;
                        else if (c == ">") two = pts_pkg::SYM_NE;
                    end
                    S_GREATER:
                    begin
                        one = pts_pkg::SYM_GT;
                        if (c == "=") two = pts_pkg::SYM_GE;
                    end
                    default:
                    begin
                        one = pts_pkg::SYM_PERIOD;
                        if (c == ".") two = pts_pkg::SYM_DOTDOT;
                    end
                endcase
                if (two != pts_pkg::SYM_NONE)
                begin
                    p_len = sat_inc(p_len);
                    push_token(pts_pkg::KIND_SPEC, two, pts_pkg::ERR_NONE, '0, '0, '0, '0);
                    p_mode = S_IDLE;
                    return;
                end
                push_token(pts_pkg::KIND_SPEC, one, pts_pkg::ERR_NONE, '0, '0, '0, '0);
                redo = 1'b1;
            end
            default:
            begin
                start_from_idle(c, col);
            end
        endcase
    endtask

    task automatic close_pending();
        case (p_mode)
            S_WORD: push_token(pts_pkg::KIND_WORD, pts_pkg::SYM_NONE, pts_pkg::ERR_NONE,
                               '0, '0, '0, '0);
            S_WHOLE: push_integer();
            S_DOT:
            begin
                p_len = sat_inc(p_len);
                push_token(pts_pkg::KIND_ERROR, pts_pkg::SYM_NONE, pts_pkg::ERR_BAD_NUM,
                           '0, '0, '0, '0);
            end
            S_FRAC, S_EXP_DIGITS: push_real();
            S_EXP_START, S_EXP_SIGN:
                push_token(pts_pkg::KIND_ERROR, pts_pkg::SYM_NONE, pts_pkg::ERR_BAD_NUM,
                           '0, '0, '0, '0);
            S_STRING: push_token(pts_pkg::KIND_ERROR, pts_pkg::SYM_NONE, pts_pkg::ERR_EOF_STR,
                                 '0, '0, '0, '0);
            S_STR_QUOTE: push_token(pts_pkg::KIND_SEND, pts_pkg::SYM_NONE, pts_pkg::ERR_NONE,
                                    '0, '0, '0, '0);
            S_COLON: push_token(pts_pkg::KIND_SPEC, pts_pkg::SYM_COLON, pts_pkg::ERR_NONE,
                                '0, '0, '0, '0);
            S_LESS: push_token(pts_pkg::KIND_SPEC, pts_pkg::SYM_LT, pts_pkg::ERR_NONE,
                               '0, '0, '0, '0);
            S_GREATER: push_token(pts_pkg::KIND_SPEC, pts_pkg::SYM_GT, pts_pkg::ERR_NONE,
                                  '0, '0, '0, '0);
            S_PERIOD: push_token(pts_pkg::KIND_SPEC, pts_pkg::SYM_PERIOD, pts_pkg::ERR_NONE,
                                 '0, '0, '0, '0);
            default: ;
        endcase
        p_mode = S_IDLE;
    endtask

    // Predict the tokens of one accepted beat and mark the final one.
    task automatic predict_beat(src_beat_t b);
        int col;
        bit redo;
        col = p_col;
        step_count = 0;
        if (b.eoi)
        begin
            close_pending();
            p_tline = p_line;
            p_tcol = p_col;
            p_len = 0;
            push_token(pts_pkg::KIND_EOF, pts_pkg::SYM_NONE, pts_pkg::ERR_NONE,
                       '0, '0, '0, '0);
        end
        else
        begin
            scan_char(b.ch, col, redo);
            if (redo)
                start_from_idle(b.ch, col);
            if (b.ch == pts_pkg::CH_NL)
            begin
                p_line = sat_inc(p_line);
                p_col = 0;
            end
            else
                p_col = sat_inc(p_col);
        end
        if (step_count > 0)
            token_queue[$].last = 1'b1;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Input handshakes take effect at the rising edge; predict them there and
    // remember for the driver whether the presented beat was taken.
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            predict_beat('{ch: char_code, eoi: end_of_input});
        end
    end

    // Driver: present beats from the pending queue, change at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (source_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    src_beat_t b;
                    b = source_queue.pop_front();
                    char_code <= b.ch;
                    end_of_input <= b.eoi;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compare each accepted token beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (token_queue.size() == 0)
                report_mismatch("unexpected token beat, kind", token_kind, -1);
            else
            begin
                pts_pkg::res_t w;
                w = token_queue.pop_front();
                if (token_kind !== w.kind) report_mismatch("token_kind", token_kind, w.kind);
                if (symbol_code !== w.sym) report_mismatch("symbol_code", symbol_code, w.sym);
                if (error_code !== w.err) report_mismatch("error_code", error_code, w.err);
                if (int_value !== w.int_val) report_mismatch("int_value", int_value, w.int_val);
                if (real_mantissa !== w.mant)
                    report_mismatch("real_mantissa", real_mantissa, w.mant);
                if (real_exponent !== w.expo)
                    report_mismatch("real_exponent", real_exponent, $signed(w.expo));
                if (string_char !== w.schar) report_mismatch("string_char", string_char, w.schar);
                if (start_line !== w.line) report_mismatch("start_line", start_line, w.line);
                if (start_column !== w.col) report_mismatch("start_column", start_column, w.col);
                if (token_length !== w.len) report_mismatch("token_length", token_length, w.len);
                if (last !== w.last) report_mismatch("last", last, w.last);
            end
        end
    end

    task automatic add_text(string s);
        foreach (s[i])
            source_queue.push_back('{ch: s[i], eoi: 1'b0});
    endtask

    task automatic add_eof();
        source_queue.push_back('{ch: 8'h00, eoi: 1'b1});
    endtask

    // Random source fragment: mostly well-formed Pascal lexemes.
    task automatic add_random_fragment();
        string s;
        int n;
        s = "";
        case ($urandom_range(11))
            0: begin
                n = $urandom_range(1, 6);
                repeat (n) s = {s, string'(8'($urandom_range(97, 122)))};
                if ($urandom_range(1)) s = {s, "_9Z"};
            end
            1: s = $sformatf("%0d", $urandom_range(0, 99999));
            2: s = $sformatf("%0d.%0d", $urandom_range(999), $urandom_range(99999));
            3: s = $sformatf("%0d.%0de%s%0d", $urandom_range(99), $urandom_range(999),
                             $urandom_range(1) ? "-" : "+", $urandom_range(2100));
            4: s = $sformatf("'%s''%c'", $urandom_range(1) ? "ab c" : "", 8'($urandom_range(32, 126)));
            5: s = $urandom_range(1) ? ":=" : ($urandom_range(1) ? "<>" : ">=");
            6: s = $urandom_range(1) ? "1..9" : "<=";
            7: s = "{ x }";
            8: s = $sformatf("%0d%0d", $urandom_range(999999999), $urandom_range(999999999));
            9: s = $urandom_range(1) ? "1e" : "3.x";
            10: s = string'(8'($urandom_range(0, 255)));
            default: s = $urandom_range(1) ? "\n" : "+-*/,;=()[]^}.";
        endcase
        if (s.len() == 0)
            s = " ";
        add_text(s);
        if ($urandom_range(3) == 0)
            add_eof();
        else
            add_text($urandom_range(2) == 0 ? "\n" : " ");
    endtask

    task automatic apb_write(logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(pts_pkg::REG_EXP_LIMIT);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        p_limit = value[10:0];
    endtask

    // Let the scanner drain completely before touching the register.
    task automatic drain();
        wait (source_queue.size() == 0 && !in_valid);
        wait (token_queue.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(int idle, int stall, int count);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) add_random_fragment();
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        char_code = '0;
        end_of_input = 1'b0;
        out_ready = 1'b0;
        mismatch_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        p_mode = S_IDLE;
        p_limit = pts_pkg::EXP_LIMIT_RESET;
        p_int = 0; p_ovf = 0; p_mant = 0; p_sig = 0; p_whole = 0; p_frac = 0;
        p_kept = 0; p_exp = 0; p_neg = 0;
        p_line = 1; p_col = 0; p_tline = 1; p_tcol = 0; p_len = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed lexemes: extremes of numbers, specials, strings, errors.
        add_text("ab_1 2147483647 2147483648 1.5e+3 0.000 1..2 3.e x:=y<>z<=>=>.. ");
        add_text("'it''s\tok' {c} _ \xff+-*/,;=()[]^}.^ 1234567890123456789012.5 ");
        add_text("9e99999999999 1.0e-2047 1e");
        add_eof();
        add_text("'open");
        add_eof();
        add_text("{never closed");
        add_eof();
        drain();

        apb_write(32'd0);
        add_text("5.0 1.5e0 0.0e5000 ");
        add_eof();
        drain();

        apb_write(32'd2047);
        run_phase(0, 0, 6);
        apb_write(32'd30);
        run_phase(75, 0, 6);
        apb_write(32'd1024);
        run_phase(0, 75, 6);
        run_phase(23, 23, 6);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

### pascal_token_scanner_core.f
hw/rtl/pts_pkg.sv
hw/rtl/pts_cfg_regs.sv
hw/rtl/pts_scanner.sv
hw/rtl/pts_result_queue.sv
hw/rtl/pascal_token_scanner_core.sv
dv/testbench.sv
